// File: hdl/mch_pkg.sv
// package for the magnetometer calibrated heading unit
// types, constants and the cordic angle table; no dependencies
`timescale 1ns / 1ps
package mch_pkg;

    typedef struct packed {
        logic signed [23:0] raw_x;
        logic signed [23:0] raw_y;
        logic signed [23:0] raw_z;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] field_x;
        logic signed [23:0] field_y;
        logic signed [23:0] field_z;
        logic signed [23:0] calibrated_x;
        logic signed [23:0] calibrated_y;
        logic signed [23:0] calibrated_z;
        logic [15:0]        heading;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        inverse_gain;
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
        logic [47:0]        matrix_row0;
        logic [47:0]        matrix_row1;
        logic [47:0]        matrix_row2;
        logic signed [15:0] declination;
    } cfg_t;

    localparam logic [2:0] REG_INVERSE_GAIN = 3'd0;
    localparam logic [2:0] REG_OFFSET_X     = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y     = 3'd2;
    localparam logic [2:0] REG_OFFSET_Z     = 3'd3;
    localparam logic [2:0] REG_MATRIX_ROW0  = 3'd4;
    localparam logic [2:0] REG_MATRIX_ROW1  = 3'd5;
    localparam logic [2:0] REG_MATRIX_ROW2  = 3'd6;
    localparam logic [2:0] REG_DECLINATION  = 3'd7;

    localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAT_MIN = -24'sh800000;
    localparam int ANGLE_TABLE_LEN = 24;
    // angles in degrees q.16
    localparam logic signed [26:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [26:0] FULL_TURN = 27'sd23592960;
    localparam logic [15:0] HEADING_WRAP = 16'd46080;

    function automatic logic signed [26:0] atan_entry(input int idx);
        logic signed [26:0] v;
        case (idx)
            0: v = 27'sd2949120;
            1: v = 27'sd1740967;
            2: v = 27'sd919879;
            3: v = 27'sd466945;
            4: v = 27'sd234379;
            5: v = 27'sd117304;
            6: v = 27'sd58666;
            7: v = 27'sd29335;
            8: v = 27'sd14668;
            9: v = 27'sd7334;
            10: v = 27'sd3667;
            11: v = 27'sd1833;
            12: v = 27'sd917;
            13: v = 27'sd458;
            14: v = 27'sd229;
            15: v = 27'sd115;
            16: v = 27'sd57;
            17: v = 27'sd29;
            18: v = 27'sd14;
            19: v = 27'sd7;
            20: v = 27'sd4;
            21: v = 27'sd2;
            22: v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) begin
            r = SAT_MAX;
        end else if (v < -48'sd8388608) begin
            r = SAT_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic is_sat(input logic signed [47:0] v);
        return (v > 48'sd8388607) || (v < -48'sd8388608);
    endfunction

endpackage

// File: hdl/mch_cfg_regs.sv
// configuration register file for the heading unit
// depends on mch_pkg
`timescale 1ns / 1ps
module mch_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic [2:0]    cfg_index,
    input  logic [47:0]   cfg_data,
    output mch_pkg::cfg_t cfg
);
    mch_pkg::cfg_t cfg_reg;
    mch_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mch_pkg::REG_INVERSE_GAIN: cfg_next.inverse_gain = cfg_data[15:0];
                mch_pkg::REG_OFFSET_X:     cfg_next.offset_x = cfg_data[23:0];
                mch_pkg::REG_OFFSET_Y:     cfg_next.offset_y = cfg_data[23:0];
                mch_pkg::REG_OFFSET_Z:     cfg_next.offset_z = cfg_data[23:0];
                mch_pkg::REG_MATRIX_ROW0:  cfg_next.matrix_row0 = cfg_data;
                mch_pkg::REG_MATRIX_ROW1:  cfg_next.matrix_row1 = cfg_data;
                mch_pkg::REG_MATRIX_ROW2:  cfg_next.matrix_row2 = cfg_data;
                mch_pkg::REG_DECLINATION:  cfg_next.declination = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inverse_gain <= 16'd1715;
            cfg_reg.offset_x     <= 24'sd1807;
            cfg_reg.offset_y     <= -24'sd1362;
            cfg_reg.offset_z     <= 24'sd1262;
            cfg_reg.matrix_row0  <= 48'd68539105280426;
            cfg_reg.matrix_row1  <= 48'd1126342328173;
            cfg_reg.matrix_row2  <= 48'd1833941418639;
            cfg_reg.declination  <= -16'sd1249;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: hdl/mch_calib.sv
// scaling, hard-iron and soft-iron calibration stages
// depends on mch_pkg; four register stages with valid bits, stalls on en
`timescale 1ns / 1ps
module mch_calib (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  mch_pkg::in_item_t   in_item,
    input  mch_pkg::cfg_t       cfg,
    output logic                out_valid,
    output logic signed [23:0]  field_x,
    output logic signed [23:0]  field_y,
    output logic signed [23:0]  field_z,
    output logic signed [23:0]  cal_x,
    output logic signed [23:0]  cal_y,
    output logic signed [23:0]  cal_z,
    output logic                sat
);
    // stage 1: products
    logic signed [40:0] prod_reg [3];
    logic               v1_reg;
    // stage 2: saturated fields
    logic signed [23:0] fld_reg [3];
    logic               s2_reg;
    logic               v2_reg;
    // stage 3: matrix products
    logic signed [41:0] mp_reg [3][3];
    logic signed [23:0] fld3_reg [3];
    logic               s3_reg;
    logic               v3_reg;
    // stage 4: calibrated
    logic signed [23:0] fld4_reg [3];
    logic signed [23:0] cal_reg [3];
    logic               s4_reg;
    logic               v4_reg;

    logic signed [23:0] raw [3];
    logic signed [23:0] offs [3];
    logic [47:0]        rows [3];
    logic signed [47:0] rnd [3];
    logic signed [24:0] diff [3];
    logic signed [47:0] acc [3];
    logic signed [23:0] fld_next [3];
    logic signed [23:0] cal_next [3];
    logic               s2_next;
    logic               s4_next;

    always_comb begin
        raw[0] = in_item.raw_x;
        raw[1] = in_item.raw_y;
        raw[2] = in_item.raw_z;
        offs[0] = cfg.offset_x;
        offs[1] = cfg.offset_y;
        offs[2] = cfg.offset_z;
        rows[0] = cfg.matrix_row0;
        rows[1] = cfg.matrix_row1;
        rows[2] = cfg.matrix_row2;
        s2_next = 1'b0;
        s4_next = s3_reg;
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (48'(prod_reg[i]) + 48'sd128) >>> 8;
            fld_next[i] = mch_pkg::sat24(rnd[i]);
            s2_next = s2_next | mch_pkg::is_sat(rnd[i]);
            diff[i] = 25'(fld_reg[i]) - 25'(offs[i]);
            acc[i] = (48'(mp_reg[i][0]) + 48'(mp_reg[i][1]) + 48'(mp_reg[i][2])
                      + 48'sd8192) >>> 14;
            cal_next[i] = mch_pkg::sat24(acc[i]);
            s4_next = s4_next | mch_pkg::is_sat(acc[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= 41'(raw[i]) * $signed({25'd0, cfg.inverse_gain});
                fld_reg[i] <= fld_next[i];
                fld3_reg[i] <= fld_reg[i];
                fld4_reg[i] <= fld3_reg[i];
                cal_reg[i] <= cal_next[i];
                for (int j = 0; j < 3; j++) begin
                    mp_reg[i][j] <= 42'($signed(rows[i][47 - 16 * j -: 16])) * 42'(diff[j]);
                end
            end
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign field_x = fld4_reg[0];
    assign field_y = fld4_reg[1];
    assign field_z = fld4_reg[2];
    assign cal_x = cal_reg[0];
    assign cal_y = cal_reg[1];
    assign cal_z = cal_reg[2];
    assign sat = s4_reg;
endmodule

// File: hdl/mch_cordic.sv
// pipelined cordic atan2 with declination add and wrap to q9.7 degrees
// depends on mch_pkg; one register stage per rotation plus prep and wrap
`timescale 1ns / 1ps
module mch_cordic #(
    parameter int STAGES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [23:0]  cal_x,
    input  logic signed [23:0]  cal_y,
    input  logic signed [15:0]  declination,
    output logic                out_valid,
    output logic [15:0]         heading
);
    localparam int XW = 34;
    localparam int ZW = 27;

    logic signed [XW-1:0] x_reg [STAGES+1];
    logic signed [XW-1:0] y_reg [STAGES+1];
    logic signed [ZW-1:0] z_reg [STAGES+1];
    logic                 zero_reg [STAGES+1];
    logic                 v_reg [STAGES+2];
    logic [15:0]          hd_reg;

    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [ZW+1:0] ang;
    logic signed [ZW+1:0] r;
    logic [15:0]          h;

    always_comb begin
        x0 = XW'(cal_x) <<< 6;
        y0 = XW'(cal_y) <<< 6;
        ang = (zero_reg[STAGES] ? (ZW+2)'(0) : (ZW+2)'(z_reg[STAGES]))
              + (ZW+2)'(declination) * (ZW+2)'(512);
        r = ang;
        if (r >= (ZW+2)'(mch_pkg::FULL_TURN)) begin
            r = r - (ZW+2)'(mch_pkg::FULL_TURN);
        end else if (r < 0) begin
            r = r + (ZW+2)'(mch_pkg::FULL_TURN);
        end
        if (r < 0) begin
            r = r + (ZW+2)'(mch_pkg::FULL_TURN);
        end
        h = 16'((r + (ZW+2)'(256)) >>> 9);
        if (h >= mch_pkg::HEADING_WRAP) begin
            h = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES + 2; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < STAGES + 2; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (cal_x == 0) && (cal_y == 0);
            if (cal_x < 0) begin
                x_reg[0] <= -x0;
                y_reg[0] <= -y0;
                z_reg[0] <= mch_pkg::HALF_TURN;
            end else begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < STAGES; i++) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + mch_pkg::atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - mch_pkg::atan_entry(i);
                end
            end
            hd_reg <= h;
        end
    end

    assign out_valid = v_reg[STAGES+1];
    assign heading = hd_reg;
endmodule

// File: hdl/magnetometer_calibrated_heading_unit.sv
// top level of the magnetometer calibrated heading unit
// depends on mch_pkg, mch_cfg_regs, mch_calib, mch_cordic
`timescale 1ns / 1ps
// One item enters per cycle while the output is not stalled, and its result passes through
// four stages for scaling and calibration, one per cordic rotation, one for
// the cordic set-up and one for the declination wrap. The whole pipeline
// advances whenever the output register is empty or being taken, so a
// stalled result holds every stage in place. Config writes are taken at once.
module magnetometer_calibrated_heading_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mch_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mch_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data
);
    localparam int LAG = CORDIC_STAGES + 2;

    mch_pkg::cfg_t      cfg;
    logic               en;
    logic               cal_valid;
    logic signed [23:0] fx, fy, fz, cx, cy, cz;
    logic               sat;
    logic               hd_valid;
    logic [15:0]        heading;

    logic signed [23:0] fx_d [LAG], fy_d [LAG], fz_d [LAG];
    logic signed [23:0] cx_d [LAG], cy_d [LAG], cz_d [LAG];
    logic               sat_d [LAG];

    assign en = !m_valid || m_ready;
    assign s_ready = en;
    assign cfg_ready = 1'b1;

    mch_cfg_regs u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    mch_calib u_calib (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_item(s_data), .cfg(cfg),
        .out_valid(cal_valid),
        .field_x(fx), .field_y(fy), .field_z(fz),
        .cal_x(cx), .cal_y(cy), .cal_z(cz), .sat(sat)
    );

    mch_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(cal_valid), .cal_x(cx), .cal_y(cy),
        .declination(cfg.declination),
        .out_valid(hd_valid), .heading(heading)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_d[0] <= fx; fy_d[0] <= fy; fz_d[0] <= fz;
            cx_d[0] <= cx; cy_d[0] <= cy; cz_d[0] <= cz;
            sat_d[0] <= sat;
            for (int i = 1; i < LAG; i++) begin
                fx_d[i] <= fx_d[i-1]; fy_d[i] <= fy_d[i-1]; fz_d[i] <= fz_d[i-1];
                cx_d[i] <= cx_d[i-1]; cy_d[i] <= cy_d[i-1]; cz_d[i] <= cz_d[i-1];
                sat_d[i] <= sat_d[i-1];
            end
        end
    end

    assign m_valid = hd_valid;
    assign m_data.field_x = fx_d[LAG-1];
    assign m_data.field_y = fy_d[LAG-1];
    assign m_data.field_z = fz_d[LAG-1];
    assign m_data.calibrated_x = cx_d[LAG-1];
    assign m_data.calibrated_y = cy_d[LAG-1];
    assign m_data.calibrated_z = cz_d[LAG-1];
    assign m_data.heading = heading;
    assign m_data.saturated = sat_d[LAG-1];
endmodule
